// ===== design/lph_pkg.sv =====
`timescale 1ns / 1ps
package lph_pkg;

  localparam int KEY_BITS      = 31;
  localparam int CNT_W         = 13;
  localparam int STAT_W        = 3;
  localparam int KIND_W        = 2;
  localparam int EK_W          = 12;
  localparam int ML_W          = 8;
  localparam int DEF_MAX_SLOTS = 4096;

  localparam logic [EK_W-1:0] EK_RESET = 12'd100;
  localparam logic [ML_W-1:0] ML_RESET = 8'd128;

  // register index is paddr[2]
  localparam logic REG_EXPECTED_KEYS = 1'b0;
  localparam logic REG_MAX_LOAD      = 1'b1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [4:0] {
    OP_NONE, OP_TAKE, OP_PKEY_KEY, OP_PKEY_SCR, OP_DIV_WANT, OP_DIV_TRIAL, OP_DIV_HASH,
    OP_SET_CAND_Q, OP_SET_CAND_GROW, OP_SET_CAND_MAX, OP_CAND_INC, OP_CAND_DEC,
    OP_D_INIT, OP_D_INC, OP_CLR_INIT, OP_I_ZERO, OP_I_INC, OP_ZERO_SLOT, OP_COPY_RD,
    OP_COPY_WR, OP_GROW_TS, OP_SCR_RD, OP_PR_INIT, OP_PR_RD, OP_PR_NEXT, OP_PR_HIT,
    OP_PR_MISS, OP_INSERT, OP_REINS_PUT, OP_RESULT
  } op_t;

  typedef enum logic [4:0] {
    S_BOOT, S_IDLE, S_DISPATCH, S_WANT_START, S_WANT_WAIT, S_PS_CHECK, S_PS_TEST,
    S_PS_WAIT, S_PS_FOUND, S_PS_FAIL, S_CLR_INIT, S_CLR_SWEEP, S_PROBE_START,
    S_PROBE_WAIT, S_PROBE_RD, S_PROBE_CMP, S_PROBE_RET, S_INS_CHECK, S_INS_FINAL,
    S_COPY_RD, S_COPY_WR, S_GROW_TS, S_ZERO_SWEEP, S_REINS_RD, S_REINS_CHK,
    S_REINS_PUT, S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    PRB_INSERT, PRB_LOOKUP, PRB_REHASH, PRB_REGROW
  } pret_t;

  typedef enum logic [1:0] {
    SRCH_CLEAR, SRCH_DOWN, SRCH_GROW
  } sret_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [KIND_W-1:0] kind;
    logic              key_zero;
    logic              div_done;
    logic              rem_zero;
    logic              d_sq_gt;
    logic              cand_gt_max;
    logic              cand_le2;
    logic              i_eq_ts;
    logic              i_eq_old;
    logic              cnt_eq_ts;
    logic              probe_stop;
    logic              found;
    logic              match;
    logic              need_grow;
    logic              sd_zero;
    logic              out_busy;
  } stat_t;

endpackage

// ===== design/lph_if.sv =====
`timescale 1ns / 1ps
interface lph_in_if;
  logic                               valid;
  logic                               ready;
  logic [lph_pkg::KIND_W-1:0]         kind;
  logic [lph_pkg::KEY_BITS-1:0]       key;
  modport source (output valid, kind, key, input ready);
  modport sink (input valid, kind, key, output ready);
endinterface

interface lph_out_if;
  logic                               valid;
  logic                               ready;
  logic [lph_pkg::STAT_W-1:0]         status;
  logic [lph_pkg::CNT_W-1:0]          key_count;
  logic [lph_pkg::CNT_W-1:0]          slot_count;
  modport source (output valid, status, key_count, slot_count, input ready);
  modport sink (input valid, status, key_count, slot_count, output ready);
endinterface

// ===== design/lph_divider.sv =====
`timescale 1ns / 1ps
module lph_divider #(
  parameter int N = lph_pkg::KEY_BITS,
  parameter int M = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quot,
  output logic [M-1:0] rem
);
  import lph_pkg::*;

  localparam int CTW = $clog2(N + 1);

  logic           busy;
  logic [CTW-1:0] cnt;
  logic [N-1:0]   q;
  logic [M-1:0]   r;
  logic [M-1:0]   dv;
  logic [M:0]     shifted;
  logic [M:0]     diff;
  logic           ge;

  assign shifted = {r, q[N-1]};
  assign ge      = shifted >= {1'b0, dv};
  assign diff    = shifted - {1'b0, dv};
  assign quot    = q;
  assign rem     = r;

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CTW'(N);
      q    <= dividend;
      r    <= '0;
      dv   <= divisor;
    end else if (busy) begin
      q   <= {q[N-2:0], ge};
      r   <= ge ? diff[M-1:0] : shifted[M-1:0];
      cnt <= cnt - CTW'(1);
      if (cnt == CTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ===== design/lph_datapath.sv =====
`timescale 1ns / 1ps
module lph_datapath #(
  parameter int MAX_SLOTS = lph_pkg::DEF_MAX_SLOTS,
  parameter int AW        = $clog2(MAX_SLOTS),
  parameter int CW        = $clog2(MAX_SLOTS + 1) + 1,
  parameter int VW        = (CW > 8) ? CW : 8
) (
  input  logic             clk,
  input  logic             rst,
  lph_in_if.sink           request,
  lph_out_if.source        result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  lph_pkg::cmd_t    cmd,
  output lph_pkg::stat_t   stat
);
  import lph_pkg::*;

  logic [EK_W-1:0]     ek;
  logic [ML_W-1:0]     ml;
  logic [ML_W-1:0]     ml_eff;
  logic [KIND_W-1:0]   kind_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] pkey;
  logic [CW-1:0]       ts;
  logic [CW-1:0]       old_ts;
  logic [CW-1:0]       nk;
  logic [CW-1:0]       cand;
  logic [CW-1:0]       dt;
  logic [CW-1:0]       i;
  logic [CW-1:0]       cnt;
  logic [AW-1:0]       idx;
  logic [KEY_BITS-1:0] rd;
  logic [KEY_BITS-1:0] sd;
  logic                found;
  logic                match;

  logic [KEY_BITS-1:0] slot_mem [MAX_SLOTS];
  logic [KEY_BITS-1:0] scr_mem [MAX_SLOTS];

  logic                div_start;
  logic [KEY_BITS-1:0] div_dvd;
  logic [VW-1:0]       div_dvs;
  logic                div_done;
  logic [KEY_BITS-1:0] div_q;
  logic [VW-1:0]       div_r;
  logic [19:0]         want;
  logic [CW-1:0]       cand_q;
  logic [CW-1:0]       idx_p1;
  logic [2*CW-1:0]     d_sq;
  logic [CW+8:0]       load_need;
  logic [CW+8:0]       load_lim;

  logic                slot_we;
  logic [AW-1:0]       slot_wa;
  logic [KEY_BITS-1:0] slot_wd;
  logic                slot_re;
  logic [AW-1:0]       slot_ra;

  assign ml_eff = (ml == '0) ? ML_W'(1) : ml;
  assign want   = {ek, 8'h00} + 20'(ml_eff) - 20'd1;

  assign div_start = (cmd.op == OP_DIV_WANT) || (cmd.op == OP_DIV_TRIAL) ||
                     (cmd.op == OP_DIV_HASH);

  always_comb begin
    case (cmd.op)
      OP_DIV_WANT: begin
        div_dvd = KEY_BITS'(want);
        div_dvs = VW'(ml_eff);
      end
      OP_DIV_TRIAL: begin
        div_dvd = KEY_BITS'(cand);
        div_dvs = VW'(dt);
      end
      default: begin
        div_dvd = pkey;
        div_dvs = VW'(ts);
      end
    endcase
  end

  lph_divider #(.N(KEY_BITS), .M(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_comb begin
    if (div_q > KEY_BITS'(MAX_SLOTS)) begin
      cand_q = CW'(MAX_SLOTS + 1);
    end else if (div_q < KEY_BITS'(2)) begin
      cand_q = CW'(2);
    end else begin
      cand_q = CW'(div_q);
    end
  end

  assign idx_p1    = CW'(idx) + CW'(1);
  assign d_sq      = {{CW{1'b0}}, dt} * {{CW{1'b0}}, dt};
  assign load_need = {(CW + 1)'(nk) + (CW + 1)'(1), 8'h00};
  assign load_lim  = (CW + 9)'(ml_eff) * (CW + 9)'(ts);

  always_comb begin
    stat.in_valid    = request.valid;
    stat.kind        = kind_r;
    stat.key_zero    = (key_r == '0);
    stat.div_done    = div_done;
    stat.rem_zero    = (div_r == '0);
    stat.d_sq_gt     = d_sq > (2 * CW)'(cand);
    stat.cand_gt_max = cand > CW'(MAX_SLOTS);
    stat.cand_le2    = cand <= CW'(2);
    stat.i_eq_ts     = (i == ts);
    stat.i_eq_old    = (i == old_ts);
    stat.cnt_eq_ts   = (cnt == ts);
    stat.probe_stop  = (rd == pkey) || (rd == '0);
    stat.found       = found;
    stat.match       = match;
    stat.need_grow   = load_need > load_lim;
    stat.sd_zero     = (sd == '0);
    stat.out_busy    = result.valid && !result.ready;
  end

  assign request.ready = (cmd.op == OP_TAKE);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LOAD) ? {24'h0, ml} : {20'h0, ek};

  always_ff @(posedge clk) begin
    if (rst) begin
      ek <= EK_RESET;
      ml <= ML_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_EXPECTED_KEYS) begin
        ek <= pwdata[EK_W-1:0];
      end else begin
        ml <= pwdata[ML_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ts <= CW'(2);
      nk <= '0;
    end else begin
      case (cmd.op)
        OP_CLR_INIT: begin
          ts <= cand;
          nk <= '0;
        end
        OP_GROW_TS: ts <= cand;
        OP_INSERT:  nk <= nk + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TAKE: begin
        kind_r <= request.kind;
        key_r  <= request.key;
      end
      OP_PKEY_KEY:      pkey <= key_r;
      OP_PKEY_SCR:      pkey <= sd;
      OP_SET_CAND_Q:    cand <= cand_q;
      OP_SET_CAND_GROW: cand <= {ts[CW-2:0], 1'b0};
      OP_SET_CAND_MAX:  cand <= CW'(MAX_SLOTS);
      OP_CAND_INC:      cand <= cand + CW'(1);
      OP_CAND_DEC:      cand <= cand - CW'(1);
      OP_D_INIT:        dt <= CW'(2);
      OP_D_INC:         dt <= dt + CW'(1);
      OP_CLR_INIT:      i <= '0;
      OP_I_ZERO:        i <= '0;
      OP_I_INC:         i <= i + CW'(1);
      OP_ZERO_SLOT:     i <= i + CW'(1);
      OP_COPY_WR:       i <= i + CW'(1);
      OP_REINS_PUT:     i <= i + CW'(1);
      OP_GROW_TS: begin
        old_ts <= ts;
        i      <= '0;
      end
      OP_PR_INIT: begin
        idx <= div_r[AW-1:0];
        cnt <= '0;
      end
      OP_PR_NEXT: begin
        idx <= (idx_p1 >= ts) ? '0 : idx_p1[AW-1:0];
        cnt <= cnt + CW'(1);
      end
      OP_PR_HIT: begin
        found <= 1'b1;
        match <= (rd == pkey);
      end
      OP_PR_MISS: begin
        found <= 1'b0;
        match <= 1'b0;
      end
      default: ;
    endcase
  end

  // slot memory, one write and one registered read port
  assign slot_we = (cmd.op == OP_ZERO_SLOT) || (cmd.op == OP_INSERT) ||
                   ((cmd.op == OP_REINS_PUT) && found);
  assign slot_wa = (cmd.op == OP_ZERO_SLOT) ? i[AW-1:0] : idx;
  assign slot_wd = (cmd.op == OP_ZERO_SLOT) ? '0 : pkey;
  assign slot_re = (cmd.op == OP_COPY_RD) || (cmd.op == OP_PR_RD);
  assign slot_ra = (cmd.op == OP_COPY_RD) ? i[AW-1:0] : idx;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      rd <= slot_mem[slot_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COPY_WR) begin
      scr_mem[i[AW-1:0]] <= rd;
    end
    if (cmd.op == OP_SCR_RD) begin
      sd <= scr_mem[i[AW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.op == OP_RESULT) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESULT) begin
      result.status     <= cmd.status;
      result.key_count  <= CNT_W'(nk);
      result.slot_count <= CNT_W'(ts);
    end
  end

  a_keys_fit: assert property (@(posedge clk) disable iff (rst) nk <= ts)
    else $error("key count above slot count");
  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_INSERT |-> found && !match)
    else $error("insert without free slot");
  a_result_room: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_RESULT |-> !(result.valid && !result.ready))
    else $error("result loaded over pending transfer");

endmodule

// ===== design/lph_ctrl.sv =====
`timescale 1ns / 1ps
module lph_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  lph_pkg::stat_t stat,
  output lph_pkg::cmd_t  cmd
);
  import lph_pkg::*;

  state_t            state, state_next;
  pret_t             pret, pret_next;
  sret_t             sret, sret_next;
  logic              resp, resp_next;
  logic [STAT_W-1:0] status_r, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_BOOT;
      pret     <= PRB_INSERT;
      sret     <= SRCH_CLEAR;
      resp     <= 1'b0;
      status_r <= ST_INSERTED;
    end else begin
      state    <= state_next;
      pret     <= pret_next;
      sret     <= sret_next;
      resp     <= resp_next;
      status_r <= status_next;
    end
  end

  always_comb begin
    state_next  = state;
    pret_next   = pret;
    sret_next   = sret;
    resp_next   = resp;
    status_next = status_r;
    case (state)
      S_BOOT: begin
        resp_next  = 1'b0;
        state_next = S_WANT_START;
      end
      S_IDLE: begin
        if (stat.in_valid) begin
          resp_next  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.kind)
          KIND_INSERT: begin
            if (stat.key_zero) begin
              status_next = ST_PRESENT;
              state_next  = S_RESULT;
            end else begin
              pret_next  = PRB_INSERT;
              state_next = S_PROBE_START;
            end
          end
          KIND_LOOKUP: begin
            if (stat.key_zero) begin
              status_next = ST_NOT_FOUND;
              state_next  = S_RESULT;
            end else begin
              pret_next  = PRB_LOOKUP;
              state_next = S_PROBE_START;
            end
          end
          KIND_CLEAR: state_next = S_WANT_START;
          default: begin
            status_next = ST_NOT_FOUND;
            state_next  = S_RESULT;
          end
        endcase
      end
      S_WANT_START: state_next = S_WANT_WAIT;
      S_WANT_WAIT: begin
        if (stat.div_done) begin
          sret_next  = SRCH_CLEAR;
          state_next = S_PS_CHECK;
        end
      end
      S_PS_CHECK: begin
        if (sret == SRCH_DOWN) begin
          state_next = stat.cand_le2 ? S_PS_FOUND : S_PS_TEST;
        end else begin
          state_next = stat.cand_gt_max ? S_PS_FAIL : S_PS_TEST;
        end
      end
      S_PS_TEST: state_next = stat.d_sq_gt ? S_PS_FOUND : S_PS_WAIT;
      S_PS_WAIT: begin
        if (stat.div_done) begin
          state_next = stat.rem_zero ? S_PS_CHECK : S_PS_TEST;
        end
      end
      S_PS_FOUND: state_next = (sret == SRCH_GROW) ? S_COPY_RD : S_CLR_INIT;
      S_PS_FAIL: begin
        if (sret == SRCH_GROW) begin
          status_next = ST_FULL;
          state_next  = S_RESULT;
        end else begin
          sret_next  = SRCH_DOWN;
          state_next = S_PS_CHECK;
        end
      end
      S_CLR_INIT: begin
        status_next = (sret == SRCH_DOWN) ? ST_FULL : ST_INSERTED;
        state_next  = S_CLR_SWEEP;
      end
      S_CLR_SWEEP: begin
        if (stat.i_eq_ts) begin
          state_next = resp ? S_RESULT : S_IDLE;
        end
      end
      S_PROBE_START: state_next = S_PROBE_WAIT;
      S_PROBE_WAIT: begin
        if (stat.div_done) begin
          state_next = S_PROBE_RD;
        end
      end
      S_PROBE_RD: state_next = stat.cnt_eq_ts ? S_PROBE_RET : S_PROBE_CMP;
      S_PROBE_CMP: state_next = stat.probe_stop ? S_PROBE_RET : S_PROBE_RD;
      S_PROBE_RET: begin
        case (pret)
          PRB_INSERT: state_next = S_INS_CHECK;
          PRB_LOOKUP: begin
            status_next = (stat.found && stat.match) ? ST_FOUND : ST_NOT_FOUND;
            state_next  = S_RESULT;
          end
          PRB_REHASH: state_next = S_REINS_PUT;
          default:    state_next = S_INS_FINAL;
        endcase
      end
      S_INS_CHECK: begin
        if (stat.found && stat.match) begin
          status_next = ST_PRESENT;
          state_next  = S_RESULT;
        end else if (stat.need_grow) begin
          sret_next  = SRCH_GROW;
          state_next = S_PS_CHECK;
        end else begin
          state_next = S_INS_FINAL;
        end
      end
      S_INS_FINAL: begin
        status_next = stat.found ? ST_INSERTED : ST_FULL;
        state_next  = S_RESULT;
      end
      S_COPY_RD: state_next = stat.i_eq_ts ? S_GROW_TS : S_COPY_WR;
      S_COPY_WR: state_next = S_COPY_RD;
      S_GROW_TS: state_next = S_ZERO_SWEEP;
      S_ZERO_SWEEP: begin
        if (stat.i_eq_ts) begin
          state_next = S_REINS_RD;
        end
      end
      S_REINS_RD: begin
        if (stat.i_eq_old) begin
          pret_next  = PRB_REGROW;
          state_next = S_PROBE_START;
        end else begin
          state_next = S_REINS_CHK;
        end
      end
      S_REINS_CHK: begin
        if (stat.sd_zero) begin
          state_next = S_REINS_RD;
        end else begin
          pret_next  = PRB_REHASH;
          state_next = S_PROBE_START;
        end
      end
      S_REINS_PUT: state_next = S_REINS_RD;
      S_RESULT: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.status = status_r;
    case (state)
      S_IDLE:        cmd.op = OP_TAKE;
      S_DISPATCH:    cmd.op = OP_PKEY_KEY;
      S_WANT_START:  cmd.op = OP_DIV_WANT;
      S_WANT_WAIT:   cmd.op = stat.div_done ? OP_SET_CAND_Q : OP_NONE;
      S_PS_CHECK: begin
        if (sret == SRCH_DOWN) begin
          cmd.op = stat.cand_le2 ? OP_NONE : OP_D_INIT;
        end else begin
          cmd.op = stat.cand_gt_max ? OP_NONE : OP_D_INIT;
        end
      end
      S_PS_TEST:     cmd.op = stat.d_sq_gt ? OP_NONE : OP_DIV_TRIAL;
      S_PS_WAIT: begin
        if (stat.div_done) begin
          if (!stat.rem_zero) begin
            cmd.op = OP_D_INC;
          end else begin
            cmd.op = (sret == SRCH_DOWN) ? OP_CAND_DEC : OP_CAND_INC;
          end
        end
      end
      S_PS_FOUND:    cmd.op = OP_I_ZERO;
      S_PS_FAIL:     cmd.op = (sret == SRCH_GROW) ? OP_NONE : OP_SET_CAND_MAX;
      S_CLR_INIT:    cmd.op = OP_CLR_INIT;
      S_CLR_SWEEP:   cmd.op = stat.i_eq_ts ? OP_NONE : OP_ZERO_SLOT;
      S_PROBE_START: cmd.op = OP_DIV_HASH;
      S_PROBE_WAIT:  cmd.op = stat.div_done ? OP_PR_INIT : OP_NONE;
      S_PROBE_RD:    cmd.op = stat.cnt_eq_ts ? OP_PR_MISS : OP_PR_RD;
      S_PROBE_CMP:   cmd.op = stat.probe_stop ? OP_PR_HIT : OP_PR_NEXT;
      S_INS_CHECK: begin
        if (!(stat.found && stat.match) && stat.need_grow) begin
          cmd.op = OP_SET_CAND_GROW;
        end
      end
      S_INS_FINAL:   cmd.op = stat.found ? OP_INSERT : OP_NONE;
      S_COPY_RD:     cmd.op = stat.i_eq_ts ? OP_NONE : OP_COPY_RD;
      S_COPY_WR:     cmd.op = OP_COPY_WR;
      S_GROW_TS:     cmd.op = OP_GROW_TS;
      S_ZERO_SWEEP:  cmd.op = stat.i_eq_ts ? OP_I_ZERO : OP_ZERO_SLOT;
      S_REINS_RD:    cmd.op = stat.i_eq_old ? OP_PKEY_KEY : OP_SCR_RD;
      S_REINS_CHK:   cmd.op = stat.sd_zero ? OP_I_INC : OP_PKEY_SCR;
      S_REINS_PUT:   cmd.op = OP_REINS_PUT;
      S_RESULT:      cmd.op = stat.out_busy ? OP_NONE : OP_RESULT;
      default:       cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== design/linear_probe_hash_set.sv =====
`timescale 1ns / 1ps
// lookup: dispatch, hash division, a read and a compare per probed slot, then result; plain insert
// adds an insert check and a final step; clear: size division, prime search by trial division
// (one division per divisor up to the square root of each candidate), then each new slot zeroed
// growth: old slots copied (read, then write), new slots zeroed, one probe per key reinserted
// one item at a time; a finished result may wait in its register while the next is taken
// reset runs the clear sequence for the reset sizes with no result; no transfer is taken until done
module linear_probe_hash_set #(
  parameter int MAX_SLOTS = lph_pkg::DEF_MAX_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  lph_in_if.sink      request,
  lph_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lph_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1) + 1;
  localparam int VW = (CW > 8) ? CW : 8;

  cmd_t  cmd;
  stat_t stat;

  lph_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  lph_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .AW        (AW),
    .CW        (CW),
    .VW        (VW)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule
